/* sv/bic_pkg.sv */
// ----------------------------------------------------------------------------
// BER INTEGER codec package
// Shared result kinds, error codes, queue command type and queue entry.
// ----------------------------------------------------------------------------
package bic_pkg;

  // Width of the integer side in bytes and bits.
  localparam int unsigned ValueBytes = 8;
  localparam int unsigned ValueBits  = 8 * ValueBytes;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Decode error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_INDEF    = 3'd1;
  localparam logic [2:0] ERR_BAD_LEN  = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  // Special length bytes.
  localparam logic [7:0] LEN_INDEF    = 8'h80;
  localparam logic [7:0] LEN_RESERVED = 8'hFF;

  // Work handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_VALUE,
    CMD_ERROR
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [ValueBits-1:0] data;    // value to encode or decoded value
    logic [3:0]           nbytes;  // content bytes of an encode, 1 to 8
    logic [2:0]           err;     // error code of a decode error
  } qentry_t;

endpackage

/* sv/bic_front.sv */
// ----------------------------------------------------------------------------
// BER INTEGER codec front end
// Accepts items, runs the byte-wise decode state machine and sizes encodes.
// ----------------------------------------------------------------------------
module bic_front import bic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 direction_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ValueBits-1:0] value_in_i,
  input  logic [7:0]           byte_in_i,
  input  logic                 end_of_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output qentry_t              entry_o
);

  localparam logic [1:0] PH_LENGTH   = 2'd0;
  localparam logic [1:0] PH_LENBYTES = 2'd1;
  localparam logic [1:0] PH_CONTENT  = 2'd2;

  logic [1:0]           phase_q, phase_d;
  logic [6:0]           lbl_q, lbl_d;
  logic [11:0]          clen_q, clen_d;
  logic [3:0]           cleft_q, cleft_d;
  logic [ValueBits-1:0] acc_q, acc_d;

  logic                 accept;
  logic                 dec_emit;
  cmd_e                 dec_cmd;
  logic [ValueBits-1:0] dec_val;
  logic [2:0]           dec_err;
  logic                 lk_req;
  logic [11:0]          lk_len;
  logic [11:0]          clen_step;
  logic [6:0]           lbl_step;
  logic [ValueBits-1:0] acc_base, acc_step;
  logic [3:0]           cleft_step;
  logic [3:0]           enc_len;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;

  // Minimal two's complement length: count leading bytes that only repeat
  // the sign of the byte after them.
  always_comb begin
    logic       still;
    logic [3:0] nlead;
    logic [7:0] hi, lo;
    still = 1'b1;
    nlead = 4'd0;
    for (int i = 0; i < ValueBytes - 1; i++) begin
      hi = value_in_i[ValueBits-1-8*i -: 8];
      lo = value_in_i[ValueBits-9-8*i -: 8];
      if (still && ((hi == 8'h00 && !lo[7]) || (hi == 8'hFF && lo[7]))) begin
        nlead = nlead + 4'd1;
      end else begin
        still = 1'b0;
      end
    end
    enc_len = 4'(ValueBytes) - nlead;
  end

  always_comb begin
    phase_d  = phase_q;
    lbl_d    = lbl_q;
    clen_d   = clen_q;
    cleft_d  = cleft_q;
    acc_d    = acc_q;
    dec_emit = 1'b0;
    dec_cmd  = CMD_VALUE;
    dec_val  = '0;
    dec_err  = ERR_NONE;
    lk_req   = 1'b0;
    lk_len   = '0;

    clen_step  = (clen_q <= 12'(ValueBytes)) ? {clen_q[3:0], byte_in_i}
                                             : 12'(ValueBytes + 1);
    lbl_step   = lbl_q - 7'd1;
    acc_base   = ({8'd0, cleft_q} == clen_q) ? {ValueBits{byte_in_i[7]}} : acc_q;
    acc_step   = {acc_base[ValueBits-9:0], byte_in_i};
    cleft_step = cleft_q - 4'd1;

    unique case (phase_q)
      PH_LENBYTES: begin
        clen_d = clen_step;
        lbl_d  = lbl_step;
        priority if (lbl_step == 7'd0) begin
          lk_req = 1'b1;
          lk_len = clen_step;
        end else if (end_of_data_i) begin
          dec_emit = 1'b1;
          dec_cmd  = CMD_ERROR;
          dec_err  = ERR_TRUNC;
        end
      end
      PH_CONTENT: begin
        acc_d   = acc_step;
        cleft_d = cleft_step;
        priority if (cleft_step == 4'd0) begin
          dec_emit = 1'b1;
          dec_val  = acc_step;
        end else if (end_of_data_i) begin
          dec_emit = 1'b1;
          dec_cmd  = CMD_ERROR;
          dec_err  = ERR_TRUNC;
        end
      end
      default: begin
        // Expecting a length byte; the unused phase code lands here too.
        priority if (byte_in_i == LEN_INDEF) begin
          dec_emit = 1'b1;
          dec_cmd  = CMD_ERROR;
          dec_err  = ERR_INDEF;
        end else if (byte_in_i == LEN_RESERVED) begin
          dec_emit = 1'b1;
          dec_cmd  = CMD_ERROR;
          dec_err  = ERR_BAD_LEN;
        end else if (!byte_in_i[7]) begin
          lk_req = 1'b1;
          lk_len = {5'd0, byte_in_i[6:0]};
        end else if (end_of_data_i) begin
          dec_emit = 1'b1;
          dec_cmd  = CMD_ERROR;
          dec_err  = ERR_TRUNC;
        end else begin
          lbl_d   = byte_in_i[6:0];
          clen_d  = '0;
          phase_d = PH_LENBYTES;
        end
      end
    endcase

    // The content length is now known.
    if (lk_req) begin
      priority if (lk_len > 12'(ValueBytes)) begin
        dec_emit = 1'b1;
        dec_cmd  = CMD_ERROR;
        dec_err  = ERR_TOO_LONG;
      end else if (lk_len == 12'd0) begin
        dec_emit = 1'b1;
        dec_val  = '0;
      end else if (end_of_data_i) begin
        dec_emit = 1'b1;
        dec_cmd  = CMD_ERROR;
        dec_err  = ERR_TRUNC;
      end else begin
        clen_d  = lk_len;
        cleft_d = lk_len[3:0];
        acc_d   = '0;
        phase_d = PH_CONTENT;
      end
    end

    if (dec_emit) begin
      phase_d = PH_LENGTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LENGTH;
      lbl_q   <= '0;
      clen_q  <= '0;
      cleft_q <= '0;
      acc_q   <= '0;
    end else if (accept && !direction_i) begin
      phase_q <= phase_d;
      lbl_q   <= lbl_d;
      clen_q  <= clen_d;
      cleft_q <= cleft_d;
      acc_q   <= acc_d;
    end
  end

  always_comb begin
    push_o = accept & (direction_i | dec_emit);
    if (direction_i) begin
      entry_o.cmd    = CMD_ENCODE;
      entry_o.data   = value_in_i;
      entry_o.nbytes = enc_len;
      entry_o.err    = ERR_NONE;
    end else begin
      entry_o.cmd    = dec_cmd;
      entry_o.data   = dec_val;
      entry_o.nbytes = 4'd0;
      entry_o.err    = dec_err;
    end
  end

endmodule

/* sv/bic_queue.sv */
// ----------------------------------------------------------------------------
// BER INTEGER codec work queue
// Two-entry queue that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module bic_queue import bic_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qentry_t entry_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output qentry_t head_o
);

  qentry_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* sv/bic_back.sv */
// ----------------------------------------------------------------------------
// BER INTEGER codec result sequencer
// Turns queue entries into result items and holds them in an output register.
// ----------------------------------------------------------------------------
module bic_back import bic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  qentry_t              head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           result_kind_o,
  output logic [7:0]           out_byte_o,
  output logic [ValueBits-1:0] out_value_o,
  output logic [2:0]           error_code_o,
  output logic                 last_o
);

  logic [3:0]           beat_q, beat_d;
  logic                 out_valid_q;
  logic [1:0]           kind_q, kind_d;
  logic [7:0]           byte_q, byte_d;
  logic [ValueBits-1:0] value_q, value_d;
  logic [2:0]           err_q, err_d;
  logic                 last_q, last_d;
  logic                 advance;
  logic [3:0]           sel;

  assign advance = ~empty_i & (~out_valid_q | out_ready_i);
  // Content beat k of n carries the byte n-k places up from the least
  // significant end.
  assign sel     = head_i.nbytes - beat_q;

  always_comb begin
    kind_d  = KIND_BYTE;
    byte_d  = '0;
    value_d = '0;
    err_d   = ERR_NONE;
    last_d  = 1'b1;
    beat_d  = 4'd0;
    unique case (head_i.cmd)
      CMD_ENCODE: begin
        if (beat_q == 4'd0) begin
          byte_d = {4'd0, head_i.nbytes};
        end else begin
          byte_d = head_i.data[8*sel[2:0] +: 8];
        end
        last_d = (beat_q == head_i.nbytes);
        beat_d = last_d ? 4'd0 : beat_q + 4'd1;
      end
      CMD_VALUE: begin
        kind_d  = KIND_VALUE;
        value_d = head_i.data;
      end
      default: begin
        kind_d = KIND_ERROR;
        err_d  = head_i.err;
      end
    endcase
  end

  assign pop_o = advance & last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        beat_q      <= beat_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      value_q <= value_d;
      err_q   <= err_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign out_byte_o    = byte_q;
  assign out_value_o   = value_q;
  assign error_code_o  = err_q;
  assign last_o        = last_q;

endmodule

/* sv/ber_integer_codec.sv */
// ----------------------------------------------------------------------------
// BER INTEGER codec
// Encodes 64-bit integers to BER length and content bytes, or decodes BER
// byte streams back to integers, as selected by the direction register.
// ----------------------------------------------------------------------------
// With direction at 1 each input item carries a signed 64-bit value and gives
// a short-form length byte followed by the 1 to 8 minimal two's complement
// content bytes, most significant first, with last set on the final byte.
// With direction at 0 each item carries one encoded byte; the block parses a
// short- or long-form length, collects the content bytes and returns one
// result item with the sign-extended value, or one error item (indefinite
// length, reserved length byte 0xFF, length above 8, or end of data before
// the encoding is complete). Decoding then starts over at a length byte; a
// partial decode survives a stretch of encoding. Decode takes one byte per
// clock cycle while the queue has room, and a result reaches the output register
// by way of the queue once the byte that completes it is taken. An encode item
// of n content bytes holds the output for its n+1 bytes, one per byte, which
// sets the encode rate; the two-entry queue between the front end and the
// result sequencer lets the next item be taken while those bytes go out.
// The direction register sits at byte address 0 of the APB port and must be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module ber_integer_codec import bic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ValueBits-1:0] value_in_i,
  input  logic [7:0]           byte_in_i,
  input  logic                 end_of_data_i,
  // Output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           result_kind_o,
  output logic [7:0]           out_byte_o,
  output logic [ValueBits-1:0] out_value_o,
  output logic [2:0]           error_code_o,
  output logic                 last_o
);

  // Register index, taken from the word address bit.
  localparam logic REG_DIRECTION = 1'b0;

  logic    direction_q;
  logic    cfg_write;
  logic    q_push, q_full, q_pop, q_empty;
  qentry_t q_entry, q_head;

  // The register is written in the access phase of an APB write.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_write && paddr[2] == REG_DIRECTION) begin
      direction_q <= pwdata[0];
    end
  end

  // Front end: takes one item per cycle whenever the queue has room.
  bic_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .direction_i   (direction_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_in_i    (value_in_i),
    .byte_in_i     (byte_in_i),
    .end_of_data_i (end_of_data_i),
    .full_i        (q_full),
    .push_o        (q_push),
    .entry_o       (q_entry)
  );

  bic_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back end: one result item per cycle into the output register when an entry waits and the output is free.
  bic_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .out_value_o   (out_value_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

  // An encode always carries between one and eight content bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && q_entry.cmd == CMD_ENCODE |->
      q_entry.nbytes != 4'd0 && q_entry.nbytes <= 4'(ValueBytes))
    else $error("encode length out of range");

  // In decode mode the front end never queues an encode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && !direction_q |-> q_entry.cmd != CMD_ENCODE)
    else $error("encode queued while decoding");

  // A decoded value or an error is always the only result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_BYTE |-> last_o && out_byte_o == 8'd0)
    else $error("value or error item not marked last");

  // Error codes appear on error items only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_ERROR |-> error_code_o == ERR_NONE)
    else $error("error code on a non-error item");

endmodule
